// ----- rtl/nbg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nbg_pkg - shared types and constants for the n-body gravity step
// Body record, cell control, state encodings and the 48-bit clamp.
// ----------------------------------------------------------------------------
package nbg_pkg;

  localparam int MAX_PARTICLES = 64;
  localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
  localparam int IDX_W         = 6;
  localparam int POS_W         = 48;
  localparam int MASS_W        = 32;
  localparam int GRAV_W        = 32;
  localparam int OP_W          = 2;
  localparam int TERM_W        = POS_W + 1;
  localparam int ACC_W         = TERM_W + $clog2(MAX_PARTICLES);
  localparam int SUM_W         = ACC_W + 1;

  localparam logic [GRAV_W-1:0] GRAV_RESET = 32'd16777216;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_STEP   = 2'd2;

  typedef struct packed {
    logic        [MASS_W-1:0] mass;
    logic signed [POS_W-1:0]  px;
    logic signed [POS_W-1:0]  py;
    logic signed [POS_W-1:0]  vx;
    logic signed [POS_W-1:0]  vy;
    logic signed [ACC_W-1:0]  ax;
    logic signed [ACC_W-1:0]  ay;
  } body_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic wr_acc;
    logic wr_vel;
    logic wr_pos;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    T_IDLE, T_ISTART, T_INEXT, T_PSTART, T_PWAIT, T_ISTORE, T_IROT,
    T_UPDV, T_UPDP, T_OROT
  } step_state_t;

  typedef enum logic [3:0] {
    PS_IDLE, PS_ABS, PS_SQ, PS_SUM, PS_ROOT, PS_FDIV, PS_UDIV, PS_MUL,
    PS_OUT, PS_DONE
  } pair_state_t;

  // clamp a wide signed sum to the 48-bit signed range
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'($signed({1'b0, {(POS_W-1){1'b1}}}));
    lo = SUM_W'($signed({1'b1, {(POS_W-1){1'b0}}}));
    if (v > hi) begin
      sat_pos = hi[POS_W-1:0];
    end else if (v < lo) begin
      sat_pos = lo[POS_W-1:0];
    end else begin
      sat_pos = v[POS_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/nbg_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nbg_cell - one body slot of the rotating ring
// Takes its neighbor's body on a shift, else loads or updates fields.
// ----------------------------------------------------------------------------
module nbg_cell (
  input  wire logic              clk,
  input  wire nbg_pkg::cell_ctl_t ctl,
  input  wire nbg_pkg::body_t    nb,
  input  wire nbg_pkg::body_t    wd,
  output nbg_pkg::body_t         q
);
  import nbg_pkg::*;

  body_t st;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      st <= nb;
    end else begin
      if (ctl.load) begin
        st.mass <= wd.mass;
        st.px   <= wd.px;
        st.py   <= wd.py;
        st.vx   <= wd.vx;
        st.vy   <= wd.vy;
      end
      if (ctl.wr_acc) begin
        st.ax <= wd.ax;
        st.ay <= wd.ay;
      end
      if (ctl.wr_vel) begin
        st.vx <= wd.vx;
        st.vy <= wd.vy;
      end
      if (ctl.wr_pos) begin
        st.px <= wd.px;
        st.py <= wd.py;
      end
    end
  end

  assign q = st;

endmodule
`default_nettype wire

// ----- rtl/nbg_pair.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nbg_pair - iterative pair acceleration unit
// Squares, root, two restoring divides and a shift-add product, one bit a cycle.
// ----------------------------------------------------------------------------
module nbg_pair (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic signed [nbg_pkg::POS_W-1:0]   pi_x,
  input  wire logic signed [nbg_pkg::POS_W-1:0]   pi_y,
  input  wire logic signed [nbg_pkg::POS_W-1:0]   pj_x,
  input  wire logic signed [nbg_pkg::POS_W-1:0]   pj_y,
  input  wire logic        [nbg_pkg::MASS_W-1:0]  mass,
  input  wire logic        [nbg_pkg::GRAV_W-1:0]  grav,
  output logic                                    done,
  output logic signed [nbg_pkg::TERM_W-1:0]       term_x,
  output logic signed [nbg_pkg::TERM_W-1:0]       term_y
);
  import nbg_pkg::*;

  localparam int D_W   = POS_W + 1;        // difference / magnitude
  localparam int S_W   = 2 * D_W;          // sum of squares
  localparam int RT_W  = D_W;              // root
  localparam int RM_W  = RT_W + 4;         // root remainder
  localparam int GM_W  = MASS_W + GRAV_W;
  localparam int NUM_W = GM_W + 24;        // G*m*2^24
  localparam int UN_W  = D_W + 32;         // |d|*2^32
  localparam int UQ_W  = 33;               // unit vector, <= 2^32
  localparam int MP_W  = NUM_W + UQ_W;
  localparam int C_W   = 7;

  pair_state_t state, state_next;
  logic [C_W-1:0] cnt;

  logic signed [D_W-1:0] dx, dy;
  logic neg_x, neg_y;
  logic [GM_W-1:0]  gm;
  logic [D_W-1:0]   mag_xr, mag_yr, mrx, mry;
  logic [S_W-1:0]   mcx, mcy, sx, sy, ssum, sq_src;
  logic [RM_W-1:0]  srem;
  logic [RT_W-1:0]  root;
  logic [S_W-1:0]   frem;
  logic [NUM_W-1:0] fq;
  logic [UN_W-1:0]  uxq, uyq;
  logic [RT_W-1:0]  uxr, uyr;
  logic [UQ_W-1:0]  umx, umy;
  logic [MP_W-1:0]  mpx, mpy;

  logic [D_W-1:0]   mag_x, mag_y;
  logic [RM_W-1:0]  rem_sh, trial;
  logic [S_W:0]     fr_sh;
  logic [RT_W:0]    ux_sh, uy_sh;
  logic [MP_W-33:0] qx, qy;
  logic [POS_W-1:0] tmx, tmy;
  logic last;

  assign mag_x  = dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
  assign mag_y  = dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
  assign rem_sh = {srem[RM_W-3:0], sq_src[S_W-1:S_W-2]};
  assign trial  = {2'b00, root, 2'b01};
  assign fr_sh  = {frem, fq[NUM_W-1]};
  assign ux_sh  = {uxr, uxq[UN_W-1]};
  assign uy_sh  = {uyr, uyq[UN_W-1]};
  assign qx     = mpx[MP_W-1:32];
  assign qy     = mpy[MP_W-1:32];
  assign tmx    = (qx > (MP_W-32)'(1) << (POS_W-1)) ? POS_W'(1) << (POS_W-1) : qx[POS_W-1:0];
  assign tmy    = (qy > (MP_W-32)'(1) << (POS_W-1)) ? POS_W'(1) << (POS_W-1) : qy[POS_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    last       = 1'b0;
    unique case (state)
      PS_IDLE: if (start) state_next = PS_ABS;
      PS_ABS: begin
        state_next = (dx == '0 && dy == '0) ? PS_DONE : PS_SQ;
      end
      PS_SQ: begin
        last = (cnt == C_W'(D_W - 1));
        if (last) state_next = PS_SUM;
      end
      PS_SUM: state_next = PS_ROOT;
      PS_ROOT: begin
        last = (cnt == C_W'(RT_W - 1));
        if (last) state_next = PS_FDIV;
      end
      PS_FDIV: begin
        last = (cnt == C_W'(NUM_W - 1));
        if (last) state_next = PS_UDIV;
      end
      PS_UDIV: begin
        last = (cnt == C_W'(UN_W - 1));
        if (last) state_next = PS_MUL;
      end
      PS_MUL: begin
        last = (cnt == C_W'(UQ_W - 1));
        if (last) state_next = PS_OUT;
      end
      PS_OUT:  state_next = PS_DONE;
      PS_DONE: state_next = PS_IDLE;
      default: state_next = PS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done = (state == PS_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt <= last ? '0 : cnt + C_W'(1);
    unique case (state)
      PS_IDLE: begin
        cnt <= '0;
        dx  <= D_W'(pj_x) - D_W'(pi_x);
        dy  <= D_W'(pj_y) - D_W'(pi_y);
        gm  <= grav * mass;
      end
      PS_ABS: begin
        cnt    <= '0;
        neg_x  <= dx[D_W-1];
        neg_y  <= dy[D_W-1];
        mag_xr <= mag_x;
        mag_yr <= mag_y;
        mrx    <= mag_x;
        mry    <= mag_y;
        mcx    <= S_W'(mag_x);
        mcy    <= S_W'(mag_y);
        sx     <= '0;
        sy     <= '0;
        term_x <= '0;
        term_y <= '0;
      end
      PS_SQ: begin
        if (mrx[0]) sx <= sx + mcx;
        if (mry[0]) sy <= sy + mcy;
        mcx <= mcx << 1;
        mcy <= mcy << 1;
        mrx <= mrx >> 1;
        mry <= mry >> 1;
      end
      PS_SUM: begin
        cnt    <= '0;
        ssum   <= sx + sy;
        sq_src <= sx + sy;
        srem   <= '0;
        root   <= '0;
      end
      PS_ROOT: begin
        if (rem_sh >= trial) begin
          srem <= rem_sh - trial;
          root <= {root[RT_W-2:0], 1'b1};
        end else begin
          srem <= rem_sh;
          root <= {root[RT_W-2:0], 1'b0};
        end
        sq_src <= sq_src << 2;
        if (last) begin
          frem <= '0;
          fq   <= {gm, 24'd0};
        end
      end
      PS_FDIV: begin
        if (fr_sh >= {1'b0, ssum}) begin
          frem <= S_W'(fr_sh - {1'b0, ssum});
          fq   <= {fq[NUM_W-2:0], 1'b1};
        end else begin
          frem <= fr_sh[S_W-1:0];
          fq   <= {fq[NUM_W-2:0], 1'b0};
        end
        if (last) begin
          uxq <= {mag_xr, 32'd0};
          uyq <= {mag_yr, 32'd0};
          uxr <= '0;
          uyr <= '0;
        end
      end
      PS_UDIV: begin
        if (ux_sh >= {1'b0, root}) begin
          uxr <= RT_W'(ux_sh - {1'b0, root});
          uxq <= {uxq[UN_W-2:0], 1'b1};
        end else begin
          uxr <= ux_sh[RT_W-1:0];
          uxq <= {uxq[UN_W-2:0], 1'b0};
        end
        if (uy_sh >= {1'b0, root}) begin
          uyr <= RT_W'(uy_sh - {1'b0, root});
          uyq <= {uyq[UN_W-2:0], 1'b1};
        end else begin
          uyr <= uy_sh[RT_W-1:0];
          uyq <= {uyq[UN_W-2:0], 1'b0};
        end
        if (last) begin
          mpx <= '0;
          mpy <= '0;
        end
      end
      PS_MUL: begin
        if (cnt == '0) begin
          umx <= {uxq[UQ_W-2:0], 1'b0};
          umy <= {uyq[UQ_W-2:0], 1'b0};
          mpx <= uxq[UQ_W-1] ? MP_W'(fq) : '0;
          mpy <= uyq[UQ_W-1] ? MP_W'(fq) : '0;
        end else begin
          umx <= umx << 1;
          umy <= umy << 1;
          mpx <= (mpx << 1) + (umx[UQ_W-1] ? MP_W'(fq) : '0);
          mpy <= (mpy << 1) + (umy[UQ_W-1] ? MP_W'(fq) : '0);
        end
      end
      PS_OUT: begin
        term_x <= neg_x ? -$signed({1'b0, tmx}) : $signed({1'b0, tmx});
        term_y <= neg_y ? -$signed({1'b0, tmy}) : $signed({1'b0, tmy});
      end
      PS_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/nbody_gravity_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nbody_gravity_step - direct n-body gravity, one Euler step per request
// Bodies sit in a ring of cells; one iterative unit evaluates each pair.
// ----------------------------------------------------------------------------
//  channel  handshake              carries
//  cfg      cfg_valid/cfg_ready    cfg_data -> gravity constant (Q8.24)
//  in       in_valid/in_stall      operation, body_mass, in_pos_*, in_vel_*
//  out      out_valid/out_stall    body_index, out_pos_*, out_vel_*, last_body
//
//  Clear and append update the body set directly. A step with n bodies
//  evaluates every ordered pair: each runs the square, root, force divide,
//  unit divide and product phases plus control states; a coincident pair
//  skips the arithmetic phases.
//  Synchronous reset empties the set and restores G = 1.0.
//  in_stall is high for the whole step; a stalled output holds the step.
// ----------------------------------------------------------------------------
module nbody_gravity_step (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic        [nbg_pkg::GRAV_W-1:0] cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic        [nbg_pkg::OP_W-1:0]   operation,
  input  wire logic        [nbg_pkg::MASS_W-1:0] body_mass,
  input  wire logic signed [nbg_pkg::POS_W-1:0]  in_pos_x,
  input  wire logic signed [nbg_pkg::POS_W-1:0]  in_pos_y,
  input  wire logic signed [nbg_pkg::POS_W-1:0]  in_vel_x,
  input  wire logic signed [nbg_pkg::POS_W-1:0]  in_vel_y,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic             [nbg_pkg::IDX_W-1:0]  body_index,
  output logic signed      [nbg_pkg::POS_W-1:0]  out_pos_x,
  output logic signed      [nbg_pkg::POS_W-1:0]  out_pos_y,
  output logic signed      [nbg_pkg::POS_W-1:0]  out_vel_x,
  output logic signed      [nbg_pkg::POS_W-1:0]  out_vel_y,
  output logic                                   last_body
);
  import nbg_pkg::*;

  step_state_t state, state_next;
  logic [CNT_W-1:0]  body_count, icnt, jcnt, ocnt;
  logic [GRAV_W-1:0] grav;
  logic signed [POS_W-1:0] pix, piy;
  logic signed [ACC_W-1:0] acc_x, acc_y;

  logic in_acc, out_free, pair_start, pair_done;
  logic signed [TERM_W-1:0] term_x, term_y;
  cell_ctl_t ctl;
  cell_ctl_t cctl [MAX_PARTICLES];
  body_t cell_q [MAX_PARTICLES];
  body_t cell_nb [MAX_PARTICLES];
  body_t wd, head;
  logic signed [POS_W-1:0] v_new_x, v_new_y, p_new_x, p_new_y;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign head      = cell_q[0];

  // head updates: velocity gains acceleration, then position gains velocity
  assign v_new_x = sat_pos(SUM_W'(head.vx) + SUM_W'(head.ax));
  assign v_new_y = sat_pos(SUM_W'(head.vy) + SUM_W'(head.ay));
  assign p_new_x = sat_pos(SUM_W'(head.px) + SUM_W'(head.vx));
  assign p_new_y = sat_pos(SUM_W'(head.py) + SUM_W'(head.vy));

  always_comb begin
    wd.mass = body_mass;
    wd.px   = (state == T_UPDP) ? p_new_x : in_pos_x;
    wd.py   = (state == T_UPDP) ? p_new_y : in_pos_y;
    wd.vx   = (state == T_UPDV) ? v_new_x : in_vel_x;
    wd.vy   = (state == T_UPDV) ? v_new_y : in_vel_y;
    wd.ax   = acc_x;
    wd.ay   = acc_y;
  end

  // ring of cells: cell k takes cell k+1, the tail (k = n-1) takes the head
  for (genvar k = 0; k < MAX_PARTICLES; k++) begin : g_ring
    always_comb begin
      cctl[k].shift  = ctl.shift;
      cctl[k].load   = ctl.load && (body_count == CNT_W'(k));
      cctl[k].wr_acc = (k == 0) ? ctl.wr_acc : 1'b0;
      cctl[k].wr_vel = (k == 0) ? ctl.wr_vel : 1'b0;
      cctl[k].wr_pos = (k == 0) ? ctl.wr_pos : 1'b0;
    end
    if (k == MAX_PARTICLES - 1) begin : g_end
      assign cell_nb[k] = cell_q[0];
    end else begin : g_mid
      assign cell_nb[k] = (body_count == CNT_W'(k + 1)) ? cell_q[0] : cell_q[k + 1];
    end
    nbg_cell u_cell (
      .clk (clk),
      .ctl (cctl[k]),
      .nb  (cell_nb[k]),
      .wd  (wd),
      .q   (cell_q[k])
    );
  end

  nbg_pair u_pair (
    .clk    (clk),
    .rst    (rst),
    .start  (pair_start),
    .pi_x   (pix),
    .pi_y   (piy),
    .pj_x   (head.px),
    .pj_y   (head.py),
    .mass   (head.mass),
    .grav   (grav),
    .done   (pair_done),
    .term_x (term_x),
    .term_y (term_y)
  );

  // next state
  // Phase A: body i at the head is latched, the ring turns n times so every
  // other body passes the head, then acc goes into i and one more turn
  // brings i+1 forward. Phase B: update and report head, turn, n times.
  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE: begin
        if (in_acc && operation == OP_STEP && body_count != '0) state_next = T_ISTART;
      end
      T_ISTART: state_next = T_INEXT;
      T_INEXT: begin
        state_next = ((jcnt + CNT_W'(1)) == body_count) ? T_ISTORE : T_PSTART;
      end
      T_PSTART: state_next = T_PWAIT;
      T_PWAIT:  if (pair_done) state_next = T_INEXT;
      T_ISTORE: state_next = T_IROT;
      T_IROT: begin
        state_next = ((icnt + CNT_W'(1)) == body_count) ? T_UPDV : T_ISTART;
      end
      T_UPDV: state_next = T_UPDP;
      T_UPDP: if (out_free) state_next = T_OROT;
      T_OROT: begin
        state_next = ((ocnt + CNT_W'(1)) == body_count) ? T_IDLE : T_UPDV;
      end
      default: state_next = T_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall   = (state != T_IDLE);
    pair_start = (state == T_PSTART);
    ctl.shift  = (state == T_INEXT) || (state == T_IROT) || (state == T_OROT);
    ctl.load   = in_acc && (operation == OP_APPEND) &&
                 (body_count < CNT_W'(MAX_PARTICLES));
    ctl.wr_acc = (state == T_ISTORE);
    ctl.wr_vel = (state == T_UPDV);
    ctl.wr_pos = (state == T_UPDP) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= T_IDLE;
      body_count <= '0;
      grav       <= GRAV_RESET;
      out_valid  <= 1'b0;
      icnt       <= '0;
      jcnt       <= '0;
      ocnt       <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) grav <= cfg_data;
      if (in_acc) begin
        unique case (operation)
          OP_CLEAR:  body_count <= '0;
          OP_APPEND: begin
            if (body_count < CNT_W'(MAX_PARTICLES)) body_count <= body_count + CNT_W'(1);
          end
          OP_STEP:   icnt <= '0;
          default: begin
          end
        endcase
      end
      unique case (state)
        T_ISTART: jcnt <= '0;
        T_INEXT:  jcnt <= jcnt + CNT_W'(1);
        T_IROT: begin
          icnt <= icnt + CNT_W'(1);
          ocnt <= '0;
        end
        T_OROT:   ocnt <= ocnt + CNT_W'(1);
        default: begin
        end
      endcase
      if (state == T_UPDP && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == T_ISTART) begin
      pix   <= head.px;
      piy   <= head.py;
      acc_x <= '0;
      acc_y <= '0;
    end
    if (state == T_PWAIT && pair_done) begin
      acc_x <= acc_x + ACC_W'(term_x);
      acc_y <= acc_y + ACC_W'(term_y);
    end
    if (state == T_UPDP && out_free) begin
      body_index <= IDX_W'(ocnt);
      out_pos_x  <= p_new_x;
      out_pos_y  <= p_new_y;
      out_vel_x  <= head.vx;
      out_vel_y  <= head.vy;
      last_body  <= ((ocnt + CNT_W'(1)) == body_count);
    end
  end

endmodule
`default_nettype wire
